/* rtl/core/tbi_pkg.sv */
// Shared types, widths and saturation helpers for the barycentric interpolator.
// No dependencies; every other file in rtl/core imports this package.
package tbi_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int GUARD      = 14;
	localparam int VAL_W      = 32;
	localparam int EDGE_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * EDGE_W;
	localparam int DET_W      = PROD_W + 1;
	localparam int COEF_W     = 48;
	localparam int DIVD_W     = EDGE_W + FRAC_BITS + GUARD;
	localparam int CNT_W      = $clog2(DIVD_W);
	localparam int QDEPTH     = 4;
	localparam int QAW        = $clog2(QDEPTH);

	typedef enum logic {
		OP_SETUP = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		SU_IDLE,
		SU_MUL,
		SU_DET,
		SU_DIV,
		SU_DONE
	} su_state_t;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		op_t                     op;
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [COORD_BITS-1:0] bx;
		logic signed [COORD_BITS-1:0] by;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic signed [VAL_W-1:0] val_a;
		logic signed [VAL_W-1:0] val_b;
		logic signed [VAL_W-1:0] val_c;
	} item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} su_stat_t;

	typedef struct packed {
		logic                    valid;
		logic signed [VAL_W-1:0] wa;
		logic signed [VAL_W-1:0] wb;
		logic signed [VAL_W-1:0] wc;
		logic                    in_tri;
		logic signed [VAL_W-1:0] iv;
	} pix_res_t;

	function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
		logic signed [63:0] r;
		if (v[64] != v[63])
			r = v[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		else
			r = v[63:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v[63:31] != {33{v[63]}})
			r = v[63] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

/* rtl/core/tbi_front.sv */
// Front end: takes input beats, already tagged setup or pixel, and queues them.
// Depends on tbi_pkg.
module tbi_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tbi_pkg::item_t in_item,
	output logic          q_valid,
	output tbi_pkg::item_t q_item,
	input  logic          q_pop
);
	import tbi_pkg::*;

	item_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           push;
	logic           pop;

	assign in_ready = (cnt_q != (QAW+1)'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// the op tag arrives already classified from the opcode bit
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= in_item;
	end

endmodule

/* rtl/core/tbi_setup.sv */
// Triangle setup: edge terms, determinant, and a bit-serial divider that
// forms the four coefficients. Holds the triangle state. Depends on tbi_pkg.
module tbi_setup (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  tbi_pkg::item_t        item,
	input  logic                  ack_take,
	output tbi_pkg::su_stat_t     stat,
	output tbi_pkg::coef_t        coeff [4],
	output logic signed [tbi_pkg::COORD_BITS-1:0] anchor_x,
	output logic signed [tbi_pkg::COORD_BITS-1:0] anchor_y,
	output logic                  zero_area
);
	import tbi_pkg::*;

	su_state_t                  state_q, state_d;
	logic signed [EDGE_W-1:0]   e_q [4];
	logic signed [PROD_W-1:0]   p0_q, p1_q;
	logic signed [DET_W-1:0]    det_q;
	logic [DET_W-1:0]           dmag;
	logic [1:0]                 idx_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [DIVD_W-1:0]          divd_q;
	logic [DET_W-1:0]           rem_q;
	logic [DET_W:0]             rem_sh;
	logic                       qbit;
	logic [DET_W-1:0]           rem_nx;
	logic [DIVD_W-1:0]          quo_nx;
	logic                       neg;
	coef_t                      coeff_q [4];
	logic                       last_bit;

	assign dmag   = det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
	assign rem_sh = {rem_q, divd_q[DIVD_W-1]};
	assign qbit   = (rem_sh >= {1'b0, dmag});
	assign rem_nx = qbit ? DET_W'(rem_sh - {1'b0, dmag}) : rem_sh[DET_W-1:0];
	assign quo_nx = {divd_q[DIVD_W-2:0], qbit};
	assign neg    = e_q[idx_q][EDGE_W-1] ^ det_q[DET_W-1];
	assign last_bit = (cnt_q == CNT_W'(DIVD_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= SU_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		stat    = '{busy: 1'b1, done: 1'b0};
		case (state_q)
			SU_IDLE: begin
				stat.busy = 1'b0;
				if (start)
					state_d = SU_MUL;
			end
			SU_MUL:  state_d = SU_DET;
			SU_DET:  state_d = (p0_q == p1_q) ? SU_DONE : SU_DIV;
			SU_DIV: begin
				if (last_bit && idx_q == 2'd3)
					state_d = SU_DONE;
			end
			SU_DONE: begin
				stat.done = 1'b1;
				if (ack_take)
					state_d = SU_IDLE;
			end
			default: state_d = SU_IDLE;
		endcase
	end

	// triangle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				coeff_q[i] <= '0;
			anchor_x  <= '0;
			anchor_y  <= '0;
			zero_area <= 1'b1;
		end else begin
			if (state_q == SU_IDLE && start) begin
				anchor_x <= item.cx;
				anchor_y <= item.cy;
			end
			if (state_q == SU_DET) begin
				zero_area <= (p0_q == p1_q);
				if (p0_q == p1_q)
					for (int i = 0; i < 4; i++)
						coeff_q[i] <= '0;
			end
			if (state_q == SU_DIV && last_bit)
				coeff_q[idx_q] <= neg ? -COEF_W'(quo_nx) : COEF_W'(quo_nx);
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			SU_IDLE: begin
				e_q[0] <= EDGE_W'(item.by) - EDGE_W'(item.cy);
				e_q[1] <= EDGE_W'(item.cx) - EDGE_W'(item.bx);
				e_q[2] <= EDGE_W'(item.cy) - EDGE_W'(item.ay);
				e_q[3] <= EDGE_W'(item.ax) - EDGE_W'(item.cx);
			end
			SU_MUL: begin
				p0_q <= e_q[0] * e_q[3];
				p1_q <= e_q[1] * e_q[2];
			end
			SU_DET: begin
				det_q  <= DET_W'(p0_q) - DET_W'(p1_q);
				idx_q  <= 2'd0;
				cnt_q  <= '0;
				rem_q  <= '0;
				divd_q <= {(e_q[0][EDGE_W-1] ? EDGE_W'(-e_q[0]) : EDGE_W'(e_q[0])),
					(FRAC_BITS+GUARD)'(0)};
			end
			SU_DIV: begin
				if (last_bit) begin
					idx_q  <= idx_q + 1'b1;
					cnt_q  <= '0;
					rem_q  <= '0;
					divd_q <= {(e_q[idx_q + 1'b1][EDGE_W-1] ?
						EDGE_W'(-e_q[idx_q + 1'b1]) : EDGE_W'(e_q[idx_q + 1'b1])),
						(FRAC_BITS+GUARD)'(0)};
				end else begin
					cnt_q  <= cnt_q + 1'b1;
					rem_q  <= rem_nx;
					divd_q <= quo_nx;
				end
			end
			default: ;
		endcase
	end

	assign coeff = coeff_q;

endmodule

/* rtl/core/tbi_pixel.sv */
// Pixel pipeline: seven stages from query point to weights and interpolated
// value, one beat per cycle, stalled as a whole. Depends on tbi_pkg.
module tbi_pixel (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  tbi_pkg::item_t        item,
	input  tbi_pkg::coef_t        coeff [4],
	input  logic signed [tbi_pkg::COORD_BITS-1:0] anchor_x,
	input  logic signed [tbi_pkg::COORD_BITS-1:0] anchor_y,
	input  logic                  zero_area,
	output logic                  busy,
	output tbi_pkg::pix_res_t     res
);
	import tbi_pkg::*;

	logic [7:1] v_q;
	logic signed [EDGE_W-1:0] dx_s1, dy_s1;
	logic signed [VAL_W-1:0]  va_s [1:5];
	logic signed [VAL_W-1:0]  vb_s [1:5];
	logic signed [VAL_W-1:0]  vc_s [1:5];
	logic signed [EDGE_W+24:0] plo_s2 [4];
	logic signed [EDGE_W+23:0] phi_s2 [4];
	logic signed [63:0] prod_s3 [4];
	logic signed [VAL_W-1:0] wa_s4, wb_s4;
	logic signed [VAL_W-1:0] wa_s5, wb_s5, wc_s5;
	logic inside_s5;
	logic signed [63:0] pa_s6, pb_s6, pc_s6;
	logic signed [VAL_W-1:0] wa_s6, wb_s6, wc_s6;
	logic inside_s6;
	logic signed [VAL_W-1:0] wa_s7, wb_s7, wc_s7, iv_s7;
	logic inside_s7;

	logic signed [64:0] sum_a, sum_b;
	logic signed [63:0] acc1, acc2;
	logic signed [EDGE_W-1:0] d_sel [4];
	logic signed [VAL_W-1:0] wc_nx;

	assign busy = |v_q;
	assign res  = '{valid: v_q[7], wa: wa_s7, wb: wb_s7, wc: wc_s7, in_tri: inside_s7,
		iv: iv_s7};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (en)
			v_q <= {v_q[6:1], in_valid};
	end

	always_comb begin
		d_sel[0] = dx_s1;
		d_sel[1] = dy_s1;
		d_sel[2] = dx_s1;
		d_sel[3] = dy_s1;
		sum_a = {prod_s3[0][63], prod_s3[0]} + {prod_s3[1][63], prod_s3[1]};
		sum_b = {prod_s3[2][63], prod_s3[2]} + {prod_s3[3][63], prod_s3[3]};
		wc_nx = sat32(64'(34'sd1 <<< FRAC_BITS) - 64'(wa_s4) - 64'(wb_s4));
		acc1  = sat64({pa_s6[63], pa_s6} + {pb_s6[63], pb_s6});
		acc2  = sat64({acc1[63], acc1} + {pc_s6[63], pc_s6});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: point relative to vertex c
			dx_s1 <= EDGE_W'(item.px) - EDGE_W'(anchor_x);
			dy_s1 <= EDGE_W'(item.py) - EDGE_W'(anchor_y);
			va_s[1] <= item.val_a;
			vb_s[1] <= item.val_b;
			vc_s[1] <= item.val_c;
			for (int i = 2; i <= 5; i++) begin
				va_s[i] <= va_s[i-1];
				vb_s[i] <= vb_s[i-1];
				vc_s[i] <= vc_s[i-1];
			end
			// s2: coefficient split in two 24-bit halves
			for (int i = 0; i < 4; i++) begin
				plo_s2[i] <= d_sel[i] * $signed({1'b0, coeff[i][23:0]});
				phi_s2[i] <= d_sel[i] * $signed(coeff[i][COEF_W-1:24]);
			end
			// s3: recombine, exact in 65 bits
			for (int i = 0; i < 4; i++)
				prod_s3[i] <= sat64($signed({phi_s2[i], 24'b0}) +
					$signed({{23{plo_s2[i][EDGE_W+24]}}, plo_s2[i]}));
			// s4: arithmetic shift is the floor
			wa_s4 <= sat32(sat64(sum_a) >>> GUARD);
			wb_s4 <= sat32(sat64(sum_b) >>> GUARD);
			// s5
			wa_s5 <= wa_s4;
			wb_s5 <= wb_s4;
			wc_s5 <= wc_nx;
			inside_s5 <= !zero_area && !wa_s4[VAL_W-1] && !wb_s4[VAL_W-1] &&
				!wc_nx[VAL_W-1];
			// s6
			pa_s6 <= va_s[5] * wa_s5;
			pb_s6 <= vb_s[5] * wb_s5;
			pc_s6 <= vc_s[5] * wc_s5;
			wa_s6 <= wa_s5;
			wb_s6 <= wb_s5;
			wc_s6 <= wc_s5;
			inside_s6 <= inside_s5;
			// s7: accumulate in order a, b, c
			wa_s7     <= wa_s6;
			wb_s7     <= wb_s6;
			wc_s7     <= wc_s6;
			inside_s7 <= inside_s6;
			iv_s7     <= sat32(acc2 >>> FRAC_BITS);
		end
	end

endmodule

/* rtl/core/triangle_barycentric_interpolator.sv */
// Barycentric interpolator over one stored triangle. A setup beat runs the
// one-bit-per-cycle divider that forms the four coefficients (the divider is
// skipped for a zero-area triangle), and starts only after earlier pixels have
// left the pipeline. Pixel beats flow at one per cycle while the output is not
// stalled and no setup is busy; an accepted pixel beat passes through the queue,
// the seven pipeline stages and the output register. A four-entry queue lets
// input beats be taken while the back end is busy. Depends on tbi_pkg.
module triangle_barycentric_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic signed [15:0] ax,
	input  logic signed [15:0] ay,
	input  logic signed [15:0] bx,
	input  logic signed [15:0] by,
	input  logic signed [15:0] cx,
	input  logic signed [15:0] cy,
	input  logic signed [15:0] px,
	input  logic signed [15:0] py,
	input  logic signed [31:0] val_a,
	input  logic signed [31:0] val_b,
	input  logic signed [31:0] val_c,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic signed [31:0] weight_a,
	output logic signed [31:0] weight_b,
	output logic signed [31:0] weight_c,
	output logic        inside_res,
	output logic signed [31:0] interp_value,
	output logic        degenerate
);
	import tbi_pkg::*;

	item_t    in_item, q_item;
	logic     q_valid, q_pop, pix_pop, su_start, en, pix_busy, ack_take;
	su_stat_t su_stat;
	coef_t    coeff [4];
	logic signed [COORD_BITS-1:0] anchor_x, anchor_y;
	logic     zero_area;
	pix_res_t pres;

	always_comb begin
		in_item = '{op: opcode ? OP_PIXEL : OP_SETUP, ax: ax, ay: ay, bx: bx, by: by,
			cx: cx, cy: cy, px: px, py: py, val_a: val_a, val_b: val_b, val_c: val_c};
	end

	assign en       = !out_valid || out_ready;
	assign pix_pop  = en && q_valid && q_item.op == OP_PIXEL && !su_stat.busy;
	assign su_start = q_valid && q_item.op == OP_SETUP && !su_stat.busy && !pix_busy;
	assign q_pop    = pix_pop || su_start;
	assign ack_take = en && su_stat.done;

	tbi_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	tbi_setup u_setup (
		.clk(clk), .arst_n(arst_n), .start(su_start), .item(q_item),
		.ack_take(ack_take), .stat(su_stat), .coeff(coeff),
		.anchor_x(anchor_x), .anchor_y(anchor_y), .zero_area(zero_area)
	);

	tbi_pixel u_pixel (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(pix_pop), .item(q_item),
		.coeff(coeff), .anchor_x(anchor_x), .anchor_y(anchor_y),
		.zero_area(zero_area), .busy(pix_busy), .res(pres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= pres.valid || su_stat.done;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind         <= pres.valid;
			weight_a     <= pres.valid ? pres.wa : '0;
			weight_b     <= pres.valid ? pres.wb : '0;
			weight_c     <= pres.valid ? pres.wc : '0;
			inside_res   <= pres.valid && pres.in_tri;
			interp_value <= pres.valid ? pres.iv : '0;
			degenerate   <= zero_area;
		end
	end

	a_no_pixel_during_setup: assert property (@(posedge clk) disable iff (!arst_n)
		!(pix_pop && su_stat.busy)) else $error("pixel entered during setup");
	a_ack_alone: assert property (@(posedge clk) disable iff (!arst_n)
		!(su_stat.done && pres.valid)) else $error("setup ack collides with pixel");
	a_setup_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		su_start |-> !pix_busy) else $error("setup started with pixels in flight");
	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		su_start |=> su_stat.busy) else $error("setup did not start");

endmodule
